// ----- design/spbp_pkg.sv -----
// Shared constants, types and tables for the sprite billboard projection block.
// Standalone package; used by spbp_div and sprite_billboard_projection.
`default_nettype none

package spbp_pkg;

  // Configuration register widths and port shape
  localparam int unsigned FOV_W      = 14;
  localparam int unsigned MAXD_W     = 16;
  localparam int unsigned HOR_W      = 12;
  localparam int unsigned SCRH_W     = 13;
  localparam int unsigned SCRW_W     = 13;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOV      = 3'd0,
    CFG_MAX_DIST = 3'd1,
    CFG_HORIZON  = 3'd2,
    CFG_SCR_H    = 3'd3,
    CFG_SCR_W    = 3'd4
  } cfg_idx_e;

  // Register values after reset
  localparam logic [FOV_W-1:0]  FOV_RST      = 14'd3217;
  localparam logic [MAXD_W-1:0] MAX_DIST_RST = 16'd4096;
  localparam logic [HOR_W-1:0]  HORIZON_RST  = 12'd120;
  localparam logic [SCRH_W-1:0] SCR_H_RST    = 13'd240;
  localparam logic [SCRW_W-1:0] SCR_W_RST    = 13'd320;

  // Angles in units of 2^-16 rad
  localparam int PI_Q16     = 205887;
  localparam int TWO_PI_Q16 = 411774;

  // Nearest visible distance: 0.3 in Q8.8, rounded up
  localparam logic [15:0] NEAR_DIST = 16'd77;

  // Heading in tenths of a degree to Q16 radians with rounding:
  // floor((hd*68629 + 300) / 600), the divide by 600 as >>3 then a
  // reciprocal multiply for 75 that is exact below 2^26.
  localparam int unsigned HEAD_MUL   = 68629;
  localparam int unsigned HEAD_BIAS  = 300;
  localparam longint unsigned HEAD_RECIP = 64'd114532462;
  localparam int unsigned HEAD_SHIFT = 33;

  // Iteration counts
  localparam int unsigned CORDIC_N   = 16;
  localparam int unsigned SQRT_STEPS = 17;

  // Divider shapes
  localparam int unsigned QUO_W     = 16;
  localparam int unsigned LR_NUM_W  = 61;
  localparam int unsigned LR_DEN_W  = 45;
  localparam int unsigned TB_NUM_W  = 32;
  localparam int unsigned TB_DEN_W  = 20;

  // Per-item fields carried alongside the square root and CORDIC stages
  typedef struct packed {
    logic [15:0] sc;
    logic [10:0] sh;
    logic [10:0] sw;
    logic [12:0] ph;
    logic        zero;
  } early_t;

  // Per-item fields carried alongside the dividers
  typedef struct packed {
    logic               vis;
    logic [15:0]        distance;
    logic signed [14:0] ang;
    logic               neg_l;
    logic               neg_r;
    logic               neg_t;
    logic               neg_b;
  } late_t;

  // arctan(2^-i) in Q16 radians
  function automatic logic [15:0] cordic_atan(input int unsigned i);
    logic [15:0] v;
    case (i)
      0: v = 16'd51472;
      1: v = 16'd30385;
      2: v = 16'd16055;
      3: v = 16'd8150;
      4: v = 16'd4091;
      5: v = 16'd2047;
      6: v = 16'd1024;
      7: v = 16'd512;
      8: v = 16'd256;
      9: v = 16'd128;
      10: v = 16'd64;
      11: v = 16'd32;
      12: v = 16'd16;
      13: v = 16'd8;
      14: v = 16'd4;
      15: v = 16'd2;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- design/sprite_billboard_projection.sv -----
// Billboard sprite projection: distance, view angle, visibility and screen quad.
// One item per cycle unless the output stalls; the pipeline runs the 17-step
// square root and 16-step CORDIC, followed by four 17-stage dividers. A stall
// at the output holds the whole pipeline.
// Reset clears all valid bits and loads the register defaults.
// Depends on spbp_pkg and spbp_div.
`default_nettype none

module sprite_billboard_projection (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [spbp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [spbp_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic signed [15:0]                 object_x_i,
  input  wire logic signed [15:0]                 object_y_i,
  input  wire logic [15:0]                        object_scale_i,
  input  wire logic [10:0]                        sprite_height_i,
  input  wire logic [10:0]                        sprite_width_i,
  input  wire logic signed [15:0]                 player_x_i,
  input  wire logic signed [15:0]                 player_y_i,
  input  wire logic [11:0]                        player_heading_i,
  input  wire logic [12:0]                        player_height_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic                                    visible_o,
  output logic [15:0]                             distance_o,
  output logic signed [14:0]                      view_angle_o,
  output logic signed [15:0]                      left_column_o,
  output logic signed [15:0]                      right_column_o,
  output logic signed [15:0]                      top_row_o,
  output logic signed [15:0]                      bottom_row_o
);

  localparam int unsigned LAST  = 41;
  localparam int unsigned SQ_W  = 34;
  localparam int unsigned XW    = 28;
  localparam int unsigned ZW    = 20;
  localparam int unsigned CZ_END = 2 + spbp_pkg::CORDIC_N;
  localparam int unsigned SQ_END = 2 + spbp_pkg::SQRT_STEPS;
  localparam logic signed [21:0] PI_A     = 22'(spbp_pkg::PI_Q16);
  localparam logic signed [21:0] TWO_PI_A = 22'(spbp_pkg::TWO_PI_Q16);
  localparam logic signed [ZW-1:0] PI_Z   = ZW'(spbp_pkg::PI_Q16);

  // Configuration registers
  logic [spbp_pkg::FOV_W-1:0]  fov_q;
  logic [spbp_pkg::MAXD_W-1:0] maxd_q;
  logic [spbp_pkg::HOR_W-1:0]  hor_q;
  logic [spbp_pkg::SCRH_W-1:0] scrh_q;
  logic [spbp_pkg::SCRW_W-1:0] scrw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fov_q  <= spbp_pkg::FOV_RST;
      maxd_q <= spbp_pkg::MAX_DIST_RST;
      hor_q  <= spbp_pkg::HORIZON_RST;
      scrh_q <= spbp_pkg::SCR_H_RST;
      scrw_q <= spbp_pkg::SCR_W_RST;
    end else if (cfg_we_i) begin
      case (spbp_pkg::cfg_idx_e'(cfg_idx_i))
        spbp_pkg::CFG_FOV:      fov_q  <= cfg_data_i[spbp_pkg::FOV_W-1:0];
        spbp_pkg::CFG_MAX_DIST: maxd_q <= cfg_data_i[spbp_pkg::MAXD_W-1:0];
        spbp_pkg::CFG_HORIZON:  hor_q  <= cfg_data_i[spbp_pkg::HOR_W-1:0];
        spbp_pkg::CFG_SCR_H:    scrh_q <= cfg_data_i[spbp_pkg::SCRH_W-1:0];
        spbp_pkg::CFG_SCR_W:    scrw_q <= cfg_data_i[spbp_pkg::SCRW_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: move whenever the output register is free or taken
  logic            en;
  logic [LAST:1]   vld_q;

  assign en          = ~vld_q[LAST] | out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[LAST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAST-1:1], in_valid_i};
    end
  end

  // Stage 1: capture item, form the object vector
  logic signed [16:0] dx_q, dy_q;
  logic [11:0]        hd_q;
  spbp_pkg::early_t   side_q [1:20];
  spbp_pkg::early_t   side_d [1:20];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= {object_x_i[15], object_x_i} - {player_x_i[15], player_x_i};
      dy_q <= {object_y_i[15], object_y_i} - {player_y_i[15], player_y_i};
      hd_q <= player_heading_i;
    end
  end

  // Stage 2: squared length, CORDIC pre-rotation, heading product
  logic signed [33:0] dxx, dyy;
  logic [28:0]        m_q;
  logic [SQ_W-1:0]    sv_q [2:SQ_END];
  logic [SQ_W-1:0]    sv_d [2:SQ_END];
  logic [SQ_W-1:0]    sr_q [2:SQ_END];
  logic [SQ_W-1:0]    sr_d [2:SQ_END];
  logic signed [XW-1:0] cx_q [2:CZ_END];
  logic signed [XW-1:0] cx_d [2:CZ_END];
  logic signed [XW-1:0] cy_q [2:CZ_END];
  logic signed [XW-1:0] cy_d [2:CZ_END];
  logic signed [ZW-1:0] cz_q [2:SQ_END];
  logic signed [ZW-1:0] cz_d [2:SQ_END];

  assign dxx = 34'(dx_q) * 34'(dx_q);
  assign dyy = 34'(dy_q) * 34'(dy_q);

  always_comb begin
    logic signed [XW-1:0] x0, y0;
    logic signed [XW-1:0] xs, ys;
    logic [SQ_W:0]        trial;
    // Side fields: fix a zero sprite height at entry
    side_d[1].sc   = object_scale_i;
    side_d[1].sh   = (sprite_height_i == '0) ? 11'd1 : sprite_height_i;
    side_d[1].sw   = sprite_width_i;
    side_d[1].ph   = player_height_i;
    side_d[1].zero = 1'b0;
    side_d[2]      = side_q[1];
    side_d[2].zero = (dx_q == '0) && (dy_q == '0);
    for (int k = 3; k <= 20; k++) begin
      side_d[k] = side_q[k-1];
    end

    // Square root seed
    sv_d[2] = SQ_W'(dxx) + SQ_W'(dyy);
    sr_d[2] = '0;
    // One result bit per stage
    for (int k = 0; k < int'(spbp_pkg::SQRT_STEPS); k++) begin
      trial = {1'b0, sr_q[2+k]} + ((SQ_W+1)'(1) << (2 * (spbp_pkg::SQRT_STEPS - 1 - k)));
      if ({1'b0, sv_q[2+k]} >= trial) begin
        sv_d[3+k] = sv_q[2+k] - trial[SQ_W-1:0];
        sr_d[3+k] = (sr_q[2+k] >> 1) + (SQ_W'(1) << (2 * (spbp_pkg::SQRT_STEPS - 1 - k)));
      end else begin
        sv_d[3+k] = sv_q[2+k];
        sr_d[3+k] = sr_q[2+k] >> 1;
      end
    end

    // Turn left-half vectors by pi before the CORDIC
    x0 = {{3{dx_q[16]}}, dx_q, 8'b0};
    y0 = {{3{dy_q[16]}}, dy_q, 8'b0};
    if (dx_q[16]) begin
      cx_d[2] = -x0;
      cy_d[2] = -y0;
      cz_d[2] = dy_q[16] ? -PI_Z : PI_Z;
    end else begin
      cx_d[2] = x0;
      cy_d[2] = y0;
      cz_d[2] = '0;
    end
    // Vectoring CORDIC: drive y toward zero
    for (int i = 0; i < int'(spbp_pkg::CORDIC_N); i++) begin
      xs = cx_q[2+i] >>> i;
      ys = cy_q[2+i] >>> i;
      if (cy_q[2+i] > 0) begin
        cx_d[3+i] = cx_q[2+i] + ys;
        cy_d[3+i] = cy_q[2+i] - xs;
        cz_d[3+i] = cz_q[2+i] + $signed({4'b0, spbp_pkg::cordic_atan(i)});
      end else begin
        cx_d[3+i] = cx_q[2+i] - ys;
        cy_d[3+i] = cy_q[2+i] + xs;
        cz_d[3+i] = cz_q[2+i] - $signed({4'b0, spbp_pkg::cordic_atan(i)});
      end
    end
    // Align the angle with the square root
    for (int k = CZ_END + 1; k <= int'(SQ_END); k++) begin
      cz_d[k] = cz_q[k-1];
    end
  end

  // Heading conversion over stages 2 and 3, then delay
  logic [18:0] hq_q [3:SQ_END];
  logic [52:0] hprod;

  assign hprod = 53'(m_q[28:3]) * 53'(spbp_pkg::HEAD_RECIP);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 1; k <= 20; k++) begin
        side_q[k] <= side_d[k];
      end
      m_q <= 29'({17'b0, hd_q} * 29'(spbp_pkg::HEAD_MUL)) + 29'(spbp_pkg::HEAD_BIAS);
      hq_q[3] <= hprod[spbp_pkg::HEAD_SHIFT+18:spbp_pkg::HEAD_SHIFT];
      for (int k = 4; k <= int'(SQ_END); k++) begin
        hq_q[k] <= hq_q[k-1];
      end
      for (int k = 2; k <= int'(SQ_END); k++) begin
        sv_q[k] <= sv_d[k];
        sr_q[k] <= sr_d[k];
        cz_q[k] <= cz_d[k];
      end
      for (int k = 2; k <= int'(CZ_END); k++) begin
        cx_q[k] <= cx_d[k];
        cy_q[k] <= cy_d[k];
      end
    end
  end

  // Stage 20: saturate distance, subtract heading, wrap and round angle
  logic [15:0]        dist20_q;
  logic signed [14:0] ang20_q;
  logic [15:0]        dist20_d;
  logic signed [14:0] ang20_d;

  always_comb begin
    logic signed [21:0] z_ext, a0, a1, a2, a3, a4;
    z_ext = side_q[SQ_END].zero ? 22'sd0 : 22'(cz_q[SQ_END]);
    a0 = z_ext - $signed({3'b0, hq_q[SQ_END]});
    a1 = (a0 >= PI_A) ? a0 - TWO_PI_A : a0;
    a2 = (a1 < -PI_A) ? a1 + TWO_PI_A : a1;
    a3 = (a2 < -PI_A) ? a2 + TWO_PI_A : a2;
    a4 = (a3 + 22'sd8) >>> 4;
    ang20_d  = a4[14:0];
    dist20_d = (|sr_q[SQ_END][SQ_W-1:16]) ? 16'hFFFF : sr_q[SQ_END][15:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist20_q <= dist20_d;
      ang20_q  <= ang20_d;
    end
  end

  // Stage 21: visibility and first products
  logic               vis21_q;
  logic [15:0]        dist21_q;
  logic signed [14:0] ang21_q;
  logic [26:0]        p_dsh_q;
  logic signed [30:0] p_wa_q;
  logic [28:0]        p_ssc_q;
  logic [24:0]        p_swf_q;
  logic signed [30:0] t_prod_q;
  logic [25:0]        b_prod_q;
  logic [14:0]        mag;
  logic               vis21_d;
  logic signed [16:0] fa;
  logic signed [17:0] hdiff;

  assign mag = ang20_q[14] ? 15'(-ang20_q) : ang20_q;
  assign vis21_d = ({3'b0, mag} * 18'd6 < {4'b0, fov_q} * 18'd5)
                && (dist20_q >= spbp_pkg::NEAR_DIST) && (dist20_q < maxd_q);
  assign fa    = $signed({ang20_q[14], ang20_q, 1'b0}) + $signed({3'b0, fov_q});
  assign hdiff = $signed({5'b0, side_q[20].ph}) - $signed({2'b0, side_q[20].sc});

  always_ff @(posedge clk_i) begin
    if (en) begin
      vis21_q  <= vis21_d;
      dist21_q <= dist20_q;
      ang21_q  <= ang20_q;
      p_dsh_q  <= {11'b0, dist20_q} * {16'b0, side_q[20].sh};
      p_wa_q   <= 31'(fa) * 31'($signed({1'b0, scrw_q}));
      p_ssc_q  <= {16'b0, scrh_q} * {13'b0, side_q[20].sc};
      p_swf_q  <= {14'b0, side_q[20].sw} * {11'b0, fov_q};
      t_prod_q <= 31'(hdiff) * 31'($signed({1'b0, scrh_q}));
      b_prod_q <= {13'b0, scrh_q} * {13'b0, side_q[20].ph};
    end
  end

  // Stage 22: full-width products and row numerators
  logic               vis22_q;
  logic [15:0]        dist22_q;
  logic signed [14:0] ang22_q;
  logic [40:0]        dp_q;
  logic signed [58:0] cn_q;
  logic [53:0]        wn_q;
  logic signed [32:0] xt_q, xb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      vis22_q  <= vis21_q;
      dist22_q <= dist21_q;
      ang22_q  <= ang21_q;
      dp_q     <= {14'b0, p_dsh_q} * {27'b0, fov_q};
      cn_q     <= 59'(p_wa_q) * 59'($signed({1'b0, p_dsh_q}));
      wn_q     <= {25'b0, p_ssc_q} * {29'b0, p_swf_q};
      xt_q     <= (33'(t_prod_q) <<< 1) + $signed({14'b0, dist21_q, 3'b0});
      xb_q     <= $signed({6'b0, b_prod_q, 1'b0}) + $signed({14'b0, dist21_q, 3'b0});
    end
  end

  // Stage 23: column numerators, fold signs for unsigned division
  logic [spbp_pkg::LR_NUM_W-1:0] ul_q, ur_q;
  logic [spbp_pkg::TB_NUM_W-1:0] ut_q, ub_q;
  logic [spbp_pkg::LR_DEN_W-1:0] dlr_q;
  logic [spbp_pkg::TB_DEN_W-1:0] dtb_q;
  logic signed [61:0]            base8, xl, xr;
  spbp_pkg::late_t               late_q [23:40];
  spbp_pkg::late_t               late_d [23:40];

  assign base8 = (62'(cn_q) + $signed({21'b0, dp_q})) <<< 3;
  assign xl    = base8 - $signed({8'b0, wn_q});
  assign xr    = base8 + $signed({8'b0, wn_q});

  always_comb begin
    late_d[23].vis      = vis22_q;
    late_d[23].distance = dist22_q;
    late_d[23].ang      = ang22_q;
    late_d[23].neg_l    = xl[61];
    late_d[23].neg_r    = xr[61];
    late_d[23].neg_t    = xt_q[32];
    late_d[23].neg_b    = xb_q[32];
    for (int k = 24; k <= 40; k++) begin
      late_d[k] = late_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ul_q  <= xl[61] ? ~xl[60:0] : xl[60:0];
      ur_q  <= xr[61] ? ~xr[60:0] : xr[60:0];
      ut_q  <= xt_q[32] ? ~xt_q[31:0] : xt_q[31:0];
      ub_q  <= xb_q[32] ? ~xb_q[31:0] : xb_q[31:0];
      dlr_q <= {dp_q, 4'b0};
      dtb_q <= {dist22_q, 4'b0};
      for (int k = 23; k <= 40; k++) begin
        late_q[k] <= late_d[k];
      end
    end
  end

  // Stages 24 to 40: four dividers
  logic [spbp_pkg::QUO_W-1:0] ql, qr, qt, qb;
  logic                       ovl, ovr, ovt, ovb;

  spbp_div #(
    .NUM_W(spbp_pkg::LR_NUM_W), .DEN_W(spbp_pkg::LR_DEN_W), .QUO_W(spbp_pkg::QUO_W)
  ) u_div_left (
    .clk_i, .en_i(en), .num_i(ul_q), .den_i(dlr_q), .quo_o(ql), .ovf_o(ovl)
  );

  spbp_div #(
    .NUM_W(spbp_pkg::LR_NUM_W), .DEN_W(spbp_pkg::LR_DEN_W), .QUO_W(spbp_pkg::QUO_W)
  ) u_div_right (
    .clk_i, .en_i(en), .num_i(ur_q), .den_i(dlr_q), .quo_o(qr), .ovf_o(ovr)
  );

  spbp_div #(
    .NUM_W(spbp_pkg::TB_NUM_W), .DEN_W(spbp_pkg::TB_DEN_W), .QUO_W(spbp_pkg::QUO_W)
  ) u_div_top (
    .clk_i, .en_i(en), .num_i(ut_q), .den_i(dtb_q), .quo_o(qt), .ovf_o(ovt)
  );

  spbp_div #(
    .NUM_W(spbp_pkg::TB_NUM_W), .DEN_W(spbp_pkg::TB_DEN_W), .QUO_W(spbp_pkg::QUO_W)
  ) u_div_bot (
    .clk_i, .en_i(en), .num_i(ub_q), .den_i(dtb_q), .quo_o(qb), .ovf_o(ovb)
  );

  // Column: unfold floor quotient, saturate to 16 bit signed
  function automatic logic [15:0] col_sat(input logic [15:0] q, input logic ovf,
                                          input logic neg);
    logic [15:0] v;
    if (ovf || q[15]) begin
      v = neg ? 16'h8000 : 16'h7FFF;
    end else begin
      v = neg ? ~{1'b0, q[14:0]} : {1'b0, q[14:0]};
    end
    return v;
  endfunction

  // Row: add horizon to unfolded quotient, saturate to 16 bit signed
  function automatic logic [15:0] row_sat(input logic [15:0] q, input logic ovf,
                                          input logic neg, input logic [11:0] hor);
    logic signed [17:0] s;
    logic [15:0]        v;
    s = $signed({6'b0, hor}) + (neg ? $signed(~{2'b0, q}) : $signed({2'b0, q}));
    if (ovf) begin
      v = neg ? 16'h8000 : 16'h7FFF;
    end else if (s > 18'sd32767) begin
      v = 16'h7FFF;
    end else if (s < -18'sd32768) begin
      v = 16'h8000;
    end else begin
      v = s[15:0];
    end
    return v;
  endfunction

  // Stage 41: output register, quad only for visible objects
  always_ff @(posedge clk_i) begin
    if (en) begin
      visible_o    <= late_q[40].vis;
      distance_o   <= late_q[40].distance;
      view_angle_o <= late_q[40].ang;
      if (late_q[40].vis) begin
        left_column_o  <= col_sat(ql, ovl, late_q[40].neg_l);
        right_column_o <= col_sat(qr, ovr, late_q[40].neg_r);
        top_row_o      <= row_sat(qt, ovt, late_q[40].neg_t, hor_q);
        bottom_row_o   <= row_sat(qb, ovb, late_q[40].neg_b, hor_q);
      end else begin
        left_column_o  <= '0;
        right_column_o <= '0;
        top_row_o      <= '0;
        bottom_row_o   <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/spbp_div.sv -----
// Pipelined unsigned restoring divider with quotient overflow flag.
// Uses spbp_pkg for default widths; one item per cycle while en_i is high.
`default_nettype none

module spbp_div #(
  parameter int unsigned NUM_W = spbp_pkg::LR_NUM_W,
  parameter int unsigned DEN_W = spbp_pkg::LR_DEN_W,
  parameter int unsigned QUO_W = spbp_pkg::QUO_W
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic      [QUO_W-1:0] quo_o,
  output logic                  ovf_o
);

  localparam int unsigned CMP_W = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

  logic [NUM_W-1:0] rem_q [0:QUO_W];
  logic [NUM_W-1:0] rem_d [0:QUO_W];
  logic [DEN_W-1:0] den_q [0:QUO_W];
  logic [QUO_W-1:0] quo_q [0:QUO_W];
  logic [QUO_W-1:0] quo_d [0:QUO_W];
  logic             ovf_q [0:QUO_W];

  // Flag quotients that do not fit, then resolve one quotient bit per stage
  always_comb begin
    logic [CMP_W-1:0] trial;
    logic [CMP_W-1:0] rem_x;
    rem_d[0] = num_i;
    quo_d[0] = '0;
    for (int j = 1; j <= QUO_W; j++) begin
      trial = CMP_W'(den_q[j-1]) << (QUO_W - j);
      rem_x = CMP_W'(rem_q[j-1]);
      if (rem_x >= trial) begin
        rem_d[j] = rem_q[j-1] - trial[NUM_W-1:0];
        quo_d[j] = quo_q[j-1] | (QUO_W'(1) << (QUO_W - j));
      end else begin
        rem_d[j] = rem_q[j-1];
        quo_d[j] = quo_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem_d[0];
      quo_q[0] <= quo_d[0];
      den_q[0] <= den_i;
      ovf_q[0] <= CMP_W'(num_i) >= (CMP_W'(den_i) << QUO_W);
      for (int j = 1; j <= QUO_W; j++) begin
        rem_q[j] <= rem_d[j];
        quo_q[j] <= quo_d[j];
        den_q[j] <= den_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
      end
    end
  end

  assign quo_o = quo_q[QUO_W];
  assign ovf_o = ovf_q[QUO_W];

endmodule

`default_nettype wire

// ----- test/sprite_billboard_projection_tb.sv -----
// Testbench for the sprite billboard projection block: random and directed objects
// against a built-in projection predictor. Depends on spbp_pkg and the block's RTL.
`default_nettype none

module sprite_billboard_projection_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 60;

  typedef struct packed {
    logic signed [15:0] obj_x;
    logic signed [15:0] obj_y;
    logic [15:0]        scale;
    logic [10:0]        spr_h;
    logic [10:0]        spr_w;
    logic signed [15:0] ply_x;
    logic signed [15:0] ply_y;
    logic [11:0]        heading;
    logic [12:0]        eye_h;
  } object_t;

  typedef struct packed {
    logic               vis;
    logic [15:0]        distance;
    logic signed [14:0] ang;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic signed [15:0] top;
    logic signed [15:0] bottom;
  } quad_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [spbp_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [spbp_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  object_t obj_q = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  quad_t got;

  // Record the handshake seen at the last rising edge for the driver
  logic in_ready_o_seen = 1'b0;

  // Predictor copy of the registers
  longint fov_r = longint'(spbp_pkg::FOV_RST);
  longint maxd_r = longint'(spbp_pkg::MAX_DIST_RST);
  longint hor_r = longint'(spbp_pkg::HORIZON_RST);
  longint scrh_r = longint'(spbp_pkg::SCR_H_RST);
  longint scrw_r = longint'(spbp_pkg::SCR_W_RST);

  object_t pending_objects[$];
  quad_t   expected_quads[$];
  int errors = 0;
  int checked = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  int in_gap = 0;
  int out_gap = 0;

  always #5 clk_i = ~clk_i;

  sprite_billboard_projection u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o,
    .object_x_i(obj_q.obj_x), .object_y_i(obj_q.obj_y),
    .object_scale_i(obj_q.scale), .sprite_height_i(obj_q.spr_h),
    .sprite_width_i(obj_q.spr_w), .player_x_i(obj_q.ply_x),
    .player_y_i(obj_q.ply_y), .player_heading_i(obj_q.heading),
    .player_height_i(obj_q.eye_h),
    .out_valid_o, .out_ready_i,
    .visible_o(got.vis), .distance_o(got.distance), .view_angle_o(got.ang),
    .left_column_o(got.left), .right_column_o(got.right),
    .top_row_o(got.top), .bottom_row_o(got.bottom)
  );

  function automatic longint floor_div(longint n, longint m);
    longint q;
    q = n / m;
    if ((n % m) != 0 && ((n < 0) != (m < 0))) q--;
    return q;
  endfunction

  function automatic longint round_div(longint n, longint m);
    return floor_div(2 * n + m, 2 * m);
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Floor shift for signed values
  function automatic longint shr_floor(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Angle of the object vector, 2^-16 rad, by 16 rotation steps
  function automatic longint bearing_q16(longint y, longint x);
    longint z, xs, ys;
    longint steps[16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                          256, 128, 64, 32, 16, 8, 4, 2};
    z = 0;
    if (x == 0 && y == 0) return 0;
    x *= 256;
    y *= 256;
    if (x < 0) begin
      z = (y >= 0) ? spbp_pkg::PI_Q16 : -spbp_pkg::PI_Q16;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += steps[i];
      end else begin
        x -= ys; y += xs; z -= steps[i];
      end
    end
    return z;
  endfunction

  function automatic quad_t project_object(object_t o);
    quad_t q;
    longint dx, dy, sc, sh, sw, hd, ph, d, a16, a12, mag, d8, den, cnum, wnum;
    longint unsigned du;
    dx = longint'(o.obj_x) - longint'(o.ply_x);
    dy = longint'(o.obj_y) - longint'(o.ply_y);
    sc = o.scale; sh = o.spr_h; sw = o.spr_w; hd = o.heading; ph = o.eye_h;
    du = int_sqrt(dx * dx + dy * dy);
    if (du > 65535) du = 65535;
    d = du;
    a16 = bearing_q16(dy, dx) - (hd * 2 * spbp_pkg::PI_Q16 + 1800) / 3600;
    for (int i = 0; i < 8 && a16 >= spbp_pkg::PI_Q16; i++) a16 -= 2 * spbp_pkg::PI_Q16;
    for (int i = 0; i < 8 && a16 < -spbp_pkg::PI_Q16; i++) a16 += 2 * spbp_pkg::PI_Q16;
    a12 = shr_floor(a16 + 8, 4);
    mag = a12 < 0 ? -a12 : a12;
    q = '0;
    q.vis = (mag * 6 < fov_r * 5) && (d * 10 >= 768) && (d < maxd_r);
    q.distance = d[15:0];
    q.ang = a12[14:0];
    if (q.vis) begin
      if (sh == 0) sh = 1;
      d8 = 8 * d;
      q.top = clamp16(round_div(hor_r * d8 + scrh_r * (ph - sc), d8));
      q.bottom = clamp16(round_div(hor_r * d8 + scrh_r * ph, d8));
      den = fov_r * 16 * d * sh;
      cnum = a12 * scrw_r * 16 * d * sh + scrw_r * 8 * fov_r * d * sh;
      wnum = scrh_r * sc * sw * fov_r;
      q.left = clamp16(round_div(cnum - wnum, den));
      q.right = clamp16(round_div(cnum + wnum, den));
    end
    return q;
  endfunction

  task automatic report_mismatch(string what, longint exp_v, longint got_v);
    errors++;
    $display("mismatch %0s at result %0d: expected %0d got %0d",
             what, checked, exp_v, got_v);
  endtask

  // Drive items and stall the input and output sides in bursts
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_ready_o_seen) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(1, 3);
          in_valid_i <= 1'b0;
        end else if (pending_objects.size() > 0) begin
          obj_q <= pending_objects.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(1, 3);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Predict on input accept, check on output accept
  always @(posedge clk_i) begin
    quad_t e;
    in_ready_o_seen <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (in_valid_i && in_ready_o) begin
        expected_quads.push_back(project_object(obj_q));
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_quads.size() == 0) begin
          report_mismatch("unexpected result", 0, 1);
        end else begin
          e = expected_quads.pop_front();
          if (got.vis !== e.vis) report_mismatch("visible", e.vis, got.vis);
          if (got.distance !== e.distance)
            report_mismatch("distance", e.distance, got.distance);
          if (got.ang !== e.ang) report_mismatch("view_angle", e.ang, got.ang);
          if (got.left !== e.left) report_mismatch("left_column", e.left, got.left);
          if (got.right !== e.right) report_mismatch("right_column", e.right, got.right);
          if (got.top !== e.top) report_mismatch("top_row", e.top, got.top);
          if (got.bottom !== e.bottom)
            report_mismatch("bottom_row", e.bottom, got.bottom);
        end
        checked++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d results", checked);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Random object near the player most of the time, so many land in view
  function automatic object_t rand_object();
    object_t o;
    int span;
    o.ply_x = 16'($urandom);
    o.ply_y = 16'($urandom);
    span = ($urandom_range(0, 3) == 0) ? 32767 : int'($urandom_range(20, 3000));
    o.obj_x = 16'(int'(o.ply_x) + int'($urandom_range(0, 2 * span)) - span);
    o.obj_y = 16'(int'(o.ply_y) + int'($urandom_range(0, 2 * span)) - span);
    if ($urandom_range(0, 9) == 0) o.obj_x = 16'($urandom);
    o.scale = 16'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 8192));
    o.spr_h = 11'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 1024));
    o.spr_w = 11'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 1024));
    o.heading = 12'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3599));
    o.eye_h = 13'($urandom);
    return o;
  endfunction

  function automatic object_t make_object(int ox, int oy, int px, int py, int hd,
                                          int sc, int sh, int sw, int ph);
    object_t o;
    o.obj_x = 16'(ox); o.obj_y = 16'(oy); o.ply_x = 16'(px); o.ply_y = 16'(py);
    o.heading = 12'(hd);
    o.scale = 16'(sc); o.spr_h = 11'(sh); o.spr_w = 11'(sw); o.eye_h = 13'(ph);
    return o;
  endfunction

  task automatic wait_drained();
    while (pending_objects.size() > 0 || expected_quads.size() > 0 || in_valid_i)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write one register at a falling edge, mirror it in the predictor
  task automatic write_reg(spbp_pkg::cfg_idx_e idx, int value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[15:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      spbp_pkg::CFG_FOV:      fov_r = longint'(value & 32'h3FFF);
      spbp_pkg::CFG_MAX_DIST: maxd_r = longint'(value & 32'hFFFF);
      spbp_pkg::CFG_HORIZON:  hor_r = longint'(value & 32'h0FFF);
      spbp_pkg::CFG_SCR_H:    scrh_r = longint'(value & 32'h1FFF);
      spbp_pkg::CFG_SCR_W:    scrw_r = longint'(value & 32'h1FFF);
      default: ;
    endcase
  endtask

  task automatic configure(int fov, int maxd, int hor, int sh, int sw);
    write_reg(spbp_pkg::CFG_FOV, fov);
    write_reg(spbp_pkg::CFG_MAX_DIST, maxd);
    write_reg(spbp_pkg::CFG_HORIZON, hor);
    write_reg(spbp_pkg::CFG_SCR_H, sh);
    write_reg(spbp_pkg::CFG_SCR_W, sw);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero vector, axes, extremes, near limit, zero sprite height
    pending_objects.push_back(make_object(100, 100, 100, 100, 0, 4096, 64, 64, 2048));
    pending_objects.push_back(make_object(1000, 0, 0, 0, 0, 4096, 64, 64, 2048));
    pending_objects.push_back(make_object(-1000, 0, 0, 0, 1800, 4096, 64, 32, 2048));
    pending_objects.push_back(make_object(-1000, -1, 0, 0, 1800, 0, 1, 1024, 0));
    pending_objects.push_back(make_object(0, 1000, 0, 0, 900, 65535, 1024, 1, 8191));
    pending_objects.push_back(make_object(0, -1000, 0, 0, 2700, 4096, 0, 2047, 2048));
    pending_objects.push_back(make_object(77, 0, 0, 0, 0, 4096, 2047, 64, 2048));
    pending_objects.push_back(make_object(76, 0, 0, 0, 0, 4096, 64, 64, 2048));
    pending_objects.push_back(make_object(32767, 32767, -32768, -32768, 450,
                                          4096, 64, 64, 2048));
    pending_objects.push_back(make_object(-32768, 32767, 32767, -32768, 4095,
                                          65535, 1024, 1024, 8191));
    pending_objects.push_back(make_object(500, 20, 0, 0, 3599, 4096, 64, 64, 2048));
    pending_objects.push_back(make_object(500, 500, 0, 0, 4000, 4096, 64, 64, 2048));
    pending_objects.push_back(make_object(4095, 0, 0, 0, 0, 4096, 64, 64, 2048));
    pending_objects.push_back(make_object(4096, 0, 0, 0, 0, 4096, 64, 64, 2048));
    wait_drained();

    // Random phases through several register settings, extremes included
    configure(12868, 65535, 4095, 4096, 4096);
    repeat (150) pending_objects.push_back(rand_object());
    wait_drained();
    configure(1, 65535, 0, 1, 1);
    repeat (100) pending_objects.push_back(rand_object());
    wait_drained();
    configure(0, 0, 120, 240, 320);
    repeat (50) pending_objects.push_back(rand_object());
    wait_drained();
    configure(int'($urandom_range(1, 12868)), int'($urandom_range(1000, 65535)),
              int'($urandom_range(0, 4095)), int'($urandom_range(1, 4096)),
              int'($urandom_range(1, 4096)));
    repeat (200) pending_objects.push_back(rand_object());
    wait_drained();
    configure(16383, 30000, 2000, 8191, 8191);
    repeat (100) pending_objects.push_back(rand_object());
    wait_drained();
    configure(3217, 20000, 120, 240, 320);
    calm = 1'b1;
    repeat (150) pending_objects.push_back(rand_object());
    wait_drained();

    $display("checked %0d projections over six register settings", checked);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
